// ===== hdl/uniform_range_rejection_sampler_core_macros.svh =====
// assertion macros used by the sampler rtl
`ifndef UNIFORM_RANGE_REJECTION_SAMPLER_CORE_MACROS_SVH
`define UNIFORM_RANGE_REJECTION_SAMPLER_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define URRS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define URRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/urrs_pkg.sv =====
// shared constants, types and codes of the range rejection sampler
`timescale 1ns / 1ps
`default_nettype none

package urrs_pkg;

  localparam int SAMPLE_W = 15;
  localparam int LIMIT_W  = 31;
  localparam int OUTER_W  = 17;
  localparam int INNER_W  = 2;
  localparam int DIV_W    = 31;
  localparam int CNT_W    = 5;
  localparam int APB_AW   = 2;
  localparam int APB_DW   = 32;

  localparam logic [SAMPLE_W-1:0] SPAN_K    = 15'h7FFF;
  localparam logic [OUTER_W-1:0]  SPAN_K_X2 = OUTER_W'({SPAN_K, 1'b0});

  localparam logic [CNT_W-1:0] DIV_STEPS_WIDE   = CNT_W'(DIV_W);
  localparam logic [CNT_W-1:0] DIV_STEPS_NARROW = CNT_W'(SAMPLE_W);

  localparam logic [APB_AW-1:0] ADDR_RANGE_LIMIT = '0;

  typedef enum logic [1:0] {
    PH_TOP,
    PH_INNER,
    PH_OUTER
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_N,
    ST_PREP,
    ST_DIV_M,
    ST_DIV_S,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== hdl/urrs_if.sv =====
// valid/ready channel interfaces for samples and results
`timescale 1ns / 1ps
`default_nettype none

interface urrs_sample_if;
  import urrs_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] random_sample;

  modport source (output valid, output random_sample, input ready);
  modport sink (input valid, input random_sample, output ready);
endinterface

interface urrs_result_if;
  import urrs_pkg::*;

  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== hdl/urrs_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module urrs_div (
  input  logic                               clk,
  input  logic                               rst,
  input  urrs_pkg::div_req_t                 req,
  input  logic [urrs_pkg::DIV_W-1:0]         dividend,
  input  logic [urrs_pkg::SAMPLE_W-1:0]      divisor,
  output logic [urrs_pkg::DIV_W-1:0]         quotient,
  output logic [urrs_pkg::SAMPLE_W-1:0]      remainder,
  output urrs_pkg::div_stat_t                stat
);
  import urrs_pkg::*;

  logic [DIV_W-1:0]    shreg;
  logic [SAMPLE_W-1:0] rem;
  logic [SAMPLE_W-1:0] dsr;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic                done;
  logic [SAMPLE_W:0]   trial;
  logic [SAMPLE_W:0]   diff;
  logic                fits;

  assign trial = {rem, shreg[DIV_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out at the top, quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (req.start) begin
      shreg <= dividend;
      rem   <= '0;
      dsr   <= divisor;
    end else if (busy) begin
      shreg <= {shreg[DIV_W-2:0], fits};
      rem   <= fits ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
    end
  end

  assign quotient  = shreg;
  assign remainder = rem;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

// ===== hdl/urrs_apb.sv =====
// apb register block holding the range limit
`timescale 1ns / 1ps
`default_nettype none

module urrs_apb (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [urrs_pkg::APB_AW-1:0]    paddr,
  input  logic [urrs_pkg::APB_DW-1:0]    pwdata,
  output logic [urrs_pkg::APB_DW-1:0]    prdata,
  output logic                           pready,
  output logic [urrs_pkg::LIMIT_W-1:0]   range_limit,
  output logic                           cfg_wr
);
  import urrs_pkg::*;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_RANGE_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      range_limit <= LIMIT_W'(1);
    end else if (cfg_wr) begin
      range_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_RANGE_LIMIT) begin
      prdata = {{(APB_DW-LIMIT_W){1'b0}}, range_limit};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/uniform_range_rejection_sampler_core.sv =====
// top level of the uniform range rejection sampler
//
//  channel     dir   handshake        payload
//  sample_ch   in    valid / ready    random_sample [14:0]
//  result_ch   out   valid / ready    value [30:0]
//  apb         in    psel / penable   range_limit at byte address 0
//
//  a sample that needs a division goes through the 15-step serial divider
//  a custom draw sample (inside a chosen bucket) skips the divider and goes straight to ST_FIN
//  every range_limit write runs a derivation on the same divider
//  (31 steps for n / 32767, 15 steps for the bucket size); no sample is taken meanwhile
//  reset loads the derived values for a range limit of one directly
//  a waiting result sits in the output register; the next sample is taken meanwhile,
//  and a second result holds the fsm until the register frees
`timescale 1ns / 1ps
`default_nettype none
`include "uniform_range_rejection_sampler_core_macros.svh"

module uniform_range_rejection_sampler_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [urrs_pkg::APB_AW-1:0]  paddr,
  input  logic [urrs_pkg::APB_DW-1:0]  pwdata,
  output logic [urrs_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  urrs_sample_if.sink                  sample_ch,
  urrs_result_if.source                result_ch
);
  import urrs_pkg::*;

  logic [LIMIT_W-1:0]  range_limit;
  logic                cfg_wr;
  logic [LIMIT_W-1:0]  n_eff;
  logic [LIMIT_W-1:0]  wr_limit;

  div_req_t            div_req;
  div_stat_t           div_stat;
  logic [DIV_W-1:0]    div_dividend;
  logic [SAMPLE_W-1:0] div_divisor;
  logic [DIV_W-1:0]    div_quot;
  logic [SAMPLE_W-1:0] div_rem;

  state_t              state;
  state_t              state_next;
  phase_t              phase;
  phase_t              phase_next;
  logic [INNER_W-1:0]  inner_bucket;
  logic [INNER_W-1:0]  inner_bucket_next;
  logic [OUTER_W-1:0]  outer_bucket;
  logic [OUTER_W-1:0]  outer_bucket_next;
  logic [SAMPLE_W-1:0] sample;

  // range-derived values
  logic [OUTER_W-1:0]  bucket_cnt;
  logic [SAMPLE_W-1:0] bucket_rem;
  logic                small_rng;
  logic                deep;
  logic [INNER_W-1:0]  inner_cnt;
  logic [SAMPLE_W-1:0] inner_rem;
  logic [SAMPLE_W-1:0] draw_m;
  logic [SAMPLE_W-1:0] draw_size;

  logic [OUTER_W-1:0]  prep_b;
  logic [OUTER_W-1:0]  prep_b1;
  logic                prep_small;
  logic                prep_deep;
  logic [INNER_W-1:0]  prep_b2;
  logic [OUTER_W-1:0]  prep_sub;
  logic [OUTER_W-1:0]  prep_rem2;
  logic [SAMPLE_W-1:0] prep_m;

  logic                accept;
  logic                custom;
  logic [SAMPLE_W-1:0] draw_q;
  logic                draw_ok;
  logic                s_full;
  logic [DIV_W:0]      outer_prod;
  logic [DIV_W:0]      outer_val;
  logic [OUTER_W-1:0]  inner_val;
  logic                fin_result;
  logic [LIMIT_W-1:0]  fin_value;
  logic                fin_go;

  logic                out_valid;
  logic [LIMIT_W-1:0]  out_value;

  urrs_apb u_apb (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .range_limit (range_limit),
    .cfg_wr      (cfg_wr)
  );

  urrs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .req       (div_req),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quot),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  assign n_eff = (range_limit == '0) ? LIMIT_W'(1) : range_limit;

  // limit being written, as the divider sees it at the write edge
  assign wr_limit = (pwdata[LIMIT_W-1:0] == '0) ? LIMIT_W'(1) : pwdata[LIMIT_W-1:0];

  // derivation from n / 32767
  always_comb begin
    prep_b     = div_quot[OUTER_W-1:0];
    prep_b1    = prep_b + 1'b1;
    prep_small = n_eff <= LIMIT_W'(SPAN_K);
    prep_deep  = prep_b >= OUTER_W'(SPAN_K);
    if (prep_b1 >= SPAN_K_X2) begin
      prep_b2  = INNER_W'(2);
      prep_sub = SPAN_K_X2;
    end else if (prep_b1 >= OUTER_W'(SPAN_K)) begin
      prep_b2  = INNER_W'(1);
      prep_sub = OUTER_W'(SPAN_K);
    end else begin
      prep_b2  = '0;
      prep_sub = '0;
    end
    prep_rem2 = prep_b1 - prep_sub;
    if (prep_small) begin
      prep_m = n_eff[SAMPLE_W-1:0];
    end else if (prep_deep) begin
      prep_m = SAMPLE_W'(prep_b2) + 1'b1;
    end else begin
      prep_m = prep_b1[SAMPLE_W-1:0];
    end
  end

  // per-sample decision
  assign accept  = sample_ch.valid && sample_ch.ready;
  assign custom  = !small_rng && ((phase == PH_OUTER) || ((phase == PH_INNER) && deep));
  assign draw_q  = div_quot[SAMPLE_W-1:0];
  assign draw_ok = draw_q < draw_m;
  assign s_full  = sample == SPAN_K;

  assign outer_prod = {outer_bucket, {SAMPLE_W{1'b0}}} - {{SAMPLE_W{1'b0}}, outer_bucket};
  assign outer_val  = outer_prod + {{(DIV_W+1-SAMPLE_W){1'b0}}, sample};
  assign inner_val  = {inner_bucket, {SAMPLE_W{1'b0}}} - {{SAMPLE_W{1'b0}}, inner_bucket}
                      + {{(OUTER_W-SAMPLE_W){1'b0}}, sample};

  always_comb begin
    fin_result        = 1'b0;
    fin_value         = LIMIT_W'(draw_q);
    phase_next        = phase;
    inner_bucket_next = inner_bucket;
    outer_bucket_next = outer_bucket;
    if (small_rng) begin
      fin_result = draw_ok;
    end else if (phase == PH_OUTER) begin
      if (!s_full) begin
        phase_next = PH_TOP;
        fin_result = (outer_bucket < bucket_cnt) || (sample < bucket_rem);
        fin_value  = outer_val[LIMIT_W-1:0];
      end
    end else if ((phase == PH_INNER) && deep) begin
      if (!s_full) begin
        if ((inner_bucket < inner_cnt) || (sample < inner_rem)) begin
          outer_bucket_next = inner_val;
          phase_next        = PH_OUTER;
        end else begin
          phase_next = PH_TOP;
        end
      end
    end else begin
      phase_next = PH_TOP;
      if (draw_ok) begin
        if (deep) begin
          inner_bucket_next = draw_q[INNER_W-1:0];
          phase_next        = PH_INNER;
        end else begin
          outer_bucket_next = OUTER_W'(draw_q);
          phase_next        = PH_OUTER;
        end
      end
    end
  end

  assign fin_go = (state == ST_FIN) && (!fin_result || !out_valid || result_ch.ready);

  // next state
  always_comb begin
    state_next = state;
    if (cfg_wr) begin
      state_next = ST_DIV_N;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state_next = custom ? ST_FIN : ST_DIV_S;
          end
        end
        ST_DIV_N: begin
          if (div_stat.done) begin
            state_next = ST_PREP;
          end
        end
        ST_PREP: state_next = ST_DIV_M;
        ST_DIV_M: begin
          if (div_stat.done) begin
            state_next = ST_IDLE;
          end
        end
        ST_DIV_S: begin
          if (div_stat.done) begin
            state_next = ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            state_next = ST_IDLE;
          end
        end
        default: state_next = ST_IDLE;
      endcase
    end
  end

  // fsm outputs
  always_comb begin
    sample_ch.ready = 1'b0;
    div_req.start   = 1'b0;
    div_req.steps   = DIV_STEPS_NARROW;
    div_dividend    = {sample_ch.random_sample, {(DIV_W-SAMPLE_W){1'b0}}};
    div_divisor     = draw_size;
    if (cfg_wr) begin
      div_req.start = 1'b1;
      div_req.steps = DIV_STEPS_WIDE;
      div_dividend  = wr_limit;
      div_divisor   = SPAN_K;
    end else begin
      case (state)
        ST_IDLE: begin
          sample_ch.ready = 1'b1;
          div_req.start   = sample_ch.valid && !custom;
        end
        ST_PREP: begin
          div_req.start = 1'b1;
          div_dividend  = {SPAN_K, {(DIV_W-SAMPLE_W){1'b0}}};
          div_divisor   = prep_m;
        end
        default: div_req.start = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      phase        <= PH_TOP;
      inner_bucket <= '0;
      outer_bucket <= '0;
      bucket_cnt   <= '0;
      bucket_rem   <= SAMPLE_W'(1);
      small_rng    <= 1'b1;
      deep         <= 1'b0;
      inner_cnt    <= '0;
      inner_rem    <= SAMPLE_W'(1);
      draw_m       <= SAMPLE_W'(1);
      draw_size    <= SPAN_K;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        phase <= PH_TOP;
      end else if (fin_go) begin
        phase        <= phase_next;
        inner_bucket <= inner_bucket_next;
        outer_bucket <= outer_bucket_next;
      end
      if (state == ST_PREP) begin
        bucket_cnt <= prep_b;
        bucket_rem <= div_rem;
        small_rng  <= prep_small;
        deep       <= prep_deep;
        inner_cnt  <= prep_b2;
        inner_rem  <= prep_rem2[SAMPLE_W-1:0];
        draw_m     <= prep_m;
      end
      if ((state == ST_DIV_M) && div_stat.done) begin
        draw_size <= draw_q;
      end
      if (fin_go && fin_result) begin
        out_valid <= 1'b1;
      end else if (result_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample <= sample_ch.random_sample;
    end
    if (fin_go && fin_result) begin
      out_value <= fin_value;
    end
  end

  assign result_ch.valid = out_valid;
  assign result_ch.value = out_value;

  `URRS_ASSERT_IMP(a_value_below_limit, fin_go && fin_result, fin_value < n_eff, "result not below range limit")
  `URRS_ASSERT_IMP(a_inner_phase_deep, phase == PH_INNER, deep, "inner phase without deep range")
  `URRS_ASSERT_IMP(a_inner_bound, 1'b1, inner_bucket <= INNER_W'(2), "inner bucket out of range")
  `URRS_ASSERT_IMP(a_div_start_free, div_req.start && !cfg_wr, !div_stat.busy, "divider restarted while busy")
  `URRS_ASSERT_NEXT(a_accept_leaves_idle, accept, state != ST_IDLE, "sample transfer left fsm idle")

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// testbench for the range rejection sampler: directed and random samples checked by a built-in draw predictor
`timescale 1ns / 1ps

module tb_top;
  import urrs_pkg::*;

  localparam int unsigned K            = 32'(SPAN_K);
  localparam int unsigned K_SQ         = K * K;
  localparam int unsigned LIMIT_MAX    = 32'h7FFF_FFFF;
  localparam int          SETTLE_CYCLES = 100;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          QUIET_LIMIT   = 3000;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  urrs_sample_if sample_ch ();
  urrs_result_if result_ch ();

  uniform_range_rejection_sampler_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .sample_ch (sample_ch),
    .result_ch (result_ch)
  );

  // predictor state
  logic [LIMIT_W-1:0] limit_reg;
  phase_t             draw_phase;
  logic [INNER_W-1:0] inner_bucket;
  logic [OUTER_W-1:0] outer_bucket;

  logic [LIMIT_W-1:0] expected_values[$];
  logic [LIMIT_W-1:0] want;
  int                 error_count;
  bit                 steady_flow;
  int                 hold_requests;
  int                 hold_served;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit pick_small(input int unsigned s, input int unsigned m,
                                    output int unsigned q);
    int unsigned size;
    size = K / m;
    if (size == 0) begin
      size = 1;
    end
    q = s / size;
    return q < m;
  endfunction

  function automatic bit predict_sample(input logic [SAMPLE_W-1:0] sample,
                                        output logic [LIMIT_W-1:0] value);
    int unsigned s, n, q, nb, rem, m, nb2, rem2;
    bit deep;
    s = sample;
    n = (limit_reg == '0) ? 1 : limit_reg;
    value = '0;
    if (n <= K) begin
      if (pick_small(s, n, q)) begin
        value = LIMIT_W'(q);
        return 1'b1;
      end
      return 1'b0;
    end
    nb = n / K;
    rem = n % K;
    deep = nb >= K;
    if (draw_phase == PH_OUTER) begin
      if (s >= K) begin
        return 1'b0;
      end
      draw_phase = PH_TOP;
      if (outer_bucket < nb || s < rem) begin
        value = LIMIT_W'(s + outer_bucket * K);
        return 1'b1;
      end
      return 1'b0;
    end
    if (draw_phase == PH_INNER && deep) begin
      m = nb + 1;
      nb2 = m / K;
      rem2 = m % K;
      if (s >= K) begin
        return 1'b0;
      end
      if (inner_bucket < nb2 || s < rem2) begin
        outer_bucket = OUTER_W'(s + inner_bucket * K);
        draw_phase = PH_OUTER;
      end else begin
        draw_phase = PH_TOP;
      end
      return 1'b0;
    end
    draw_phase = PH_TOP;
    if (deep) begin
      nb2 = (nb + 1) / K;
      if (pick_small(s, nb2 + 1, q)) begin
        inner_bucket = INNER_W'(q);
        draw_phase = PH_INNER;
      end
    end else if (pick_small(s, nb + 1, q)) begin
      outer_bucket = OUTER_W'(q);
      draw_phase = PH_OUTER;
    end
    return 1'b0;
  endfunction

  function automatic logic [SAMPLE_W-1:0] next_sample();
    case ($urandom_range(0, 19))
      0: return SPAN_K;
      1: return SPAN_K - 1'b1;
      2: return SAMPLE_W'($urandom_range(0, 7));
      default: return SAMPLE_W'($urandom_range(0, K));
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    logic [LIMIT_W-1:0] v;
    bit emits;
    while (!steady_flow && $urandom_range(0, 99) < 31) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.random_sample <= s;
    do @(posedge clk); while (!sample_ch.ready);
    emits = predict_sample(s, v);
    if (emits) begin
      expected_values.push_back(v);
    end
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_sample(next_sample());
  endtask

  // drain outstanding results and let any silent draw step finish
  task automatic settle();
    sample_ch.valid <= 1'b0;
    while (expected_values.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input int unsigned n);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_RANGE_LIMIT;
    pwdata  <= APB_DW'(n);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    limit_reg  = LIMIT_W'(n);
    draw_phase = PH_TOP;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic test_reset_limit();
    send_sample('0);
    send_sample(SPAN_K - 1'b1);
    send_sample(SPAN_K);
  endtask

  task automatic test_small_ranges();
    write_limit(K);
    send_sample('0);
    send_sample(SPAN_K);
    send_sample(15'd21845);
    write_limit(2);
    send_sample(15'd16382);
    send_sample(SPAN_K - 1'b1);
  endtask

  // multiple of K: the partial bucket is empty and always restarts
  task automatic test_bucket_ranges();
    write_limit(2 * K);
    send_sample(SPAN_K - 1'b1);
    send_sample(SPAN_K - 2'd2);
    send_sample(15'd5);
    send_sample('0);
    send_sample(SPAN_K);
    send_sample(SPAN_K - 1'b1);
  endtask

  task automatic test_deep_ranges();
    write_limit(LIMIT_MAX);
    send_sample(SPAN_K - 2'd2);
    send_sample(15'd4);
    send_sample('0);
    send_sample('0);
    send_sample(SPAN_K - 1'b1);
    send_sample(SPAN_K - 1'b1);
  endtask

  // a write in the middle of a draw drops the chosen bucket
  task automatic test_abandon_draw();
    write_limit(K_SQ);
    send_sample(15'd16383);
    send_sample('0);
    write_limit(K_SQ - 1);
    send_sample(SPAN_K);
    send_sample(15'd5);
    send_sample(15'd100);
  endtask

  task automatic test_random_mix();
    int unsigned limits[9];
    limits[0] = 1;
    limits[1] = $urandom_range(2, K - 1);
    limits[2] = K + 1;
    limits[3] = $urandom_range(2, K - 1) * K;
    limits[4] = $urandom_range(K + 2, K_SQ - 2);
    limits[5] = K_SQ - 1;
    limits[6] = K_SQ;
    limits[7] = $urandom_range(K_SQ + 1, LIMIT_MAX - 1);
    limits[8] = LIMIT_MAX;
    foreach (limits[i]) begin
      write_limit(limits[i]);
      send_random(36);
    end
  endtask

  task automatic test_backpressure();
    write_limit($urandom_range(100, K));
    steady_flow = 1'b1;
    send_random(20);
    hold_requests++;
    send_random(40);
    steady_flow = 1'b0;
  endtask

  // result receiver
  initial begin : result_sink
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      result_ch.ready <= steady_flow || ($urandom_range(0, 99) >= 31);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_values.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("unexpected result transfer: value %0d", result_ch.value);
        end
      end else begin
        want = expected_values.pop_front();
        if (result_ch.value !== want) begin
          error_count++;
          if (error_count <= 10) begin
            $display("value mismatch: expected %0d, got %0d", want, result_ch.value);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (psel && penable)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("** uniform_range_rejection_sampler_core: FAILED **");
    $finish;
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_ch.valid = 1'b0;
    sample_ch.random_sample = '0;
    limit_reg = LIMIT_W'(1);
    draw_phase = PH_TOP;
    inner_bucket = '0;
    outer_bucket = '0;
    error_count = 0;
    steady_flow = 1'b0;
    hold_requests = 0;
    hold_served = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_limit();
    test_small_ranges();
    test_bucket_ranges();
    test_deep_ranges();
    test_abandon_draw();
    test_random_mix();
    test_backpressure();
    settle();

    if (error_count == 0 && expected_values.size() == 0) begin
      $display("** uniform_range_rejection_sampler_core: PASSED **");
    end else begin
      $display("** uniform_range_rejection_sampler_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/urrs_pkg.sv
hdl/urrs_if.sv
hdl/urrs_div.sv
hdl/urrs_apb.sv
hdl/uniform_range_rejection_sampler_core.sv
tb/sv/tb_top.sv
